// File: rtl/imh_pkg.sv
package imh_pkg;

  localparam int MAX_ITEMS_DEF = 1024;
  localparam int KEY_WIDTH_DEF = 32;

  localparam logic [2:0] KIND_UPDATE   = 3'd0;
  localparam logic [2:0] KIND_DECREASE = 3'd1;
  localparam logic [2:0] KIND_EXTRACT  = 3'd2;
  localparam logic [2:0] KIND_REMOVE   = 3'd3;
  localparam logic [2:0] KIND_PEEK     = 3'd4;
  localparam logic [2:0] KIND_READ     = 3'd5;
  localparam logic [2:0] KIND_REINIT   = 3'd6;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_ITEM = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_NO_DEC   = 3'd3;
  localparam logic [2:0] ST_ABSENT   = 3'd4;

  localparam logic [1:0] REG_ITEMS_IN_USE = 2'd0;
  localparam logic [1:0] REG_DEFAULT_KEY  = 2'd1;
  localparam logic [1:0] REG_START_FULL   = 2'd2;

endpackage

// File: rtl/indexed_min_heap.sv
// Indexed binary min-heap over numbered items, each with a signed key.
// Input channel (in_valid/in_stall): kind, item, new_key. One result item per
// request on the output channel (out_valid/out_stall): status, item_out,
// key_out, count, is_empty.
// Config channel (cfg_valid/cfg_ready, always ready): cfg_index selects
// items_in_use, default_key or start_full; write only while idle.
// State lives in three RAMs with registered reads: keys, heap slots, item positions.
// One request is worked at a time. Update, decrease, remove and extract may
// sift, a heap level per pass of the sequencer over the slot/key RAM ports:
// up through S_SU_CHK, S_SU_A, S_SU_B; down through S_SD_CHK, S_SD_A, S_SD_B
// and, when a right child exists, S_SD_C.
// Reinit sweeps all MAX_ITEMS entries, one per cycle, then answers.
// After reset a pass over all MAX_ITEMS entries zeroes keys and positions;
// in_stall stays high until it ends. Config writes are taken meanwhile.
// The result sits in an output register: a new request is accepted while it
// waits, and the sequencer only holds at its final step if out_stall persists.
module indexed_min_heap
  import imh_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF,
  parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_kind,
  input  logic [9:0]         in_item,
  input  logic signed [31:0] in_new_key,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic [9:0]         out_item_out,
  output logic signed [31:0] out_key_out,
  output logic [10:0]        out_count,
  output logic               out_is_empty,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int IW = $clog2(MAX_ITEMS);      // item index
  localparam int CW = $clog2(MAX_ITEMS + 1);  // heap position / count
  localparam int KW = KEY_WIDTH;

  typedef logic signed [KW-1:0] key_t;

  typedef enum logic [3:0] {
    S_SWEEP, S_IDLE, S_RD1, S_TOPKEY, S_ER_A, S_ER_B, S_ER_C,
    S_SU_CHK, S_SU_A, S_SU_B, S_SD_CHK, S_SD_A, S_SD_B, S_SD_C,
    S_PLACE, S_DONE
  } state_t;

  // memories
  key_t          key_mem  [MAX_ITEMS];
  logic [IW-1:0] slot_mem [MAX_ITEMS+1];
  logic [CW-1:0] pos_mem  [MAX_ITEMS];

  key_t          key_q;
  logic [IW-1:0] slot_q;
  logic [CW-1:0] pos_q;

  logic          key_we, slot_we, pos_we;
  logic [IW-1:0] key_wa, pos_wa, key_ra, pos_ra;
  logic [CW-1:0] slot_wa, slot_ra;
  key_t          key_wd;
  logic [IW-1:0] slot_wd;
  logic [CW-1:0] pos_wd;

  always_ff @(posedge clk) begin
    if (key_we) key_mem[key_wa] <= key_wd;
    if (slot_we) slot_mem[slot_wa] <= slot_wd;
    if (pos_we) pos_mem[pos_wa] <= pos_wd;
    key_q  <= key_mem[key_ra];
    slot_q <= slot_mem[slot_ra];
    pos_q  <= pos_mem[pos_ra];
  end

  // registers
  state_t        state_r, state_nxt;
  logic [10:0]   cfg_items_r;
  logic [31:0]   cfg_dkey_r;
  logic          cfg_full_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [IW-1:0] sw_cnt_r, sw_cnt_nxt;
  logic          sw_rep_r, sw_rep_nxt;
  logic          sw_full_r, sw_full_nxt;
  key_t          sw_key_r, sw_key_nxt;
  logic [CW-1:0] sw_n_r, sw_n_nxt;
  logic [2:0]    kind_r, kind_nxt;
  logic [9:0]    item_r, item_nxt;
  key_t          nk_r, nk_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW:0]   j_r, j_nxt;
  logic [IW-1:0] mov_r, mov_nxt, lit_r, lit_nxt, rit_r, rit_nxt;
  key_t          mkey_r, mkey_nxt, lkey_r, lkey_nxt, gone_r, gone_nxt;
  logic [2:0]    res_st_r, res_st_nxt;
  logic [9:0]    res_it_r, res_it_nxt;
  logic [31:0]   res_key_r, res_key_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [2:0]    o_st_r, o_st_nxt;
  logic [9:0]    o_it_r, o_it_nxt;
  logic [31:0]   o_key_r, o_key_nxt;
  logic [10:0]   o_cnt_r, o_cnt_nxt;
  logic          o_emp_r, o_emp_nxt;

  // effective item limit
  logic [CW-1:0] lim;
  always_comb begin
    if (32'(cfg_items_r) > 32'(MAX_ITEMS)) lim = CW'(MAX_ITEMS);
    else lim = CW'(cfg_items_r);
  end

  logic accept;
  logic addressed, bad;
  logic [CW:0] j2;
  logic [IW-1:0] c_it;
  key_t c_key;
  logic [CW:0] c_j;
  logic rd1_upd;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign addressed = (kind_r == KIND_UPDATE) || (kind_r == KIND_DECREASE) ||
                     (kind_r == KIND_REMOVE) || (kind_r == KIND_READ);
  assign bad = addressed && (32'(item_r) >= 32'(lim));

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    sw_cnt_nxt = sw_cnt_r; sw_rep_nxt = sw_rep_r; sw_full_nxt = sw_full_r;
    sw_key_nxt = sw_key_r; sw_n_nxt = sw_n_r;
    kind_nxt = kind_r; item_nxt = item_r; nk_nxt = nk_r;
    i_nxt = i_r; j_nxt = j_r;
    mov_nxt = mov_r; lit_nxt = lit_r; rit_nxt = rit_r;
    mkey_nxt = mkey_r; lkey_nxt = lkey_r; gone_nxt = gone_r;
    res_st_nxt = res_st_r; res_it_nxt = res_it_r; res_key_nxt = res_key_r;
    out_valid_nxt = out_valid_r && out_stall;
    o_st_nxt = o_st_r; o_it_nxt = o_it_r; o_key_nxt = o_key_r;
    o_cnt_nxt = o_cnt_r; o_emp_nxt = o_emp_r;
    key_we = 1'b0; slot_we = 1'b0; pos_we = 1'b0;
    key_wa = item_r[IW-1:0] ; pos_wa = key_wa; slot_wa = i_r;
    key_wd = nk_r; slot_wd = mov_r; pos_wd = '0;
    key_ra = IW'(item_r); pos_ra = IW'(item_r); slot_ra = CW'(1);
    j2 = {1'b0, i_r} << 1;
    rd1_upd = 1'b0;
    c_it = lit_r; c_key = lkey_r; c_j = j_r;

    unique case (state_r)
      S_SWEEP: begin
        key_we = 1'b1; key_wa = sw_cnt_r; key_wd = sw_key_r;
        pos_we = 1'b1; pos_wa = sw_cnt_r;
        pos_wd = (sw_full_r && (CW'(sw_cnt_r) < sw_n_r)) ? CW'(sw_cnt_r) + CW'(1) : '0;
        slot_we = sw_full_r; slot_wa = CW'(sw_cnt_r) + CW'(1); slot_wd = sw_cnt_r;
        sw_cnt_nxt = sw_cnt_r + IW'(1);
        if (32'(sw_cnt_r) == 32'(MAX_ITEMS - 1)) begin
          sw_cnt_nxt = '0;
          state_nxt = sw_rep_r ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        key_ra = IW'(in_item); pos_ra = IW'(in_item); slot_ra = CW'(1);
        if (accept) begin
          kind_nxt = in_kind;
          item_nxt = in_item;
          nk_nxt = KW'(in_new_key);
          state_nxt = S_RD1;
        end
      end
      S_RD1: begin
        res_st_nxt = ST_OK;
        res_it_nxt = addressed ? item_r : 10'd0;
        res_key_nxt = '0;
        mov_nxt = IW'(item_r);
        mkey_nxt = nk_r;
        state_nxt = S_DONE;
        if (bad) begin
          res_st_nxt = ST_BAD_ITEM;
        end else begin
          case (kind_r)
            KIND_UPDATE, KIND_DECREASE: begin
              res_key_nxt = 32'(key_q);
              if (pos_q == '0) begin
                rd1_upd = 1'b1;
                if (32'(cnt_r) < 32'(MAX_ITEMS)) begin
                  cnt_nxt = cnt_r + CW'(1);
                  i_nxt = cnt_r + CW'(1);
                  state_nxt = S_SU_CHK;
                end
              end else if (nk_r < key_q) begin
                rd1_upd = 1'b1;
                i_nxt = pos_q;
                state_nxt = S_SU_CHK;
              end else if (kind_r == KIND_DECREASE) begin
                res_st_nxt = ST_NO_DEC;
              end else if (nk_r > key_q) begin
                rd1_upd = 1'b1;
                i_nxt = pos_q;
                state_nxt = S_SD_CHK;
              end
              if (rd1_upd) begin
                key_we = 1'b1;
                res_key_nxt = 32'(nk_r);
              end
            end
            KIND_REMOVE: begin
              res_key_nxt = 32'(key_q);
              if (pos_q == '0) begin
                res_st_nxt = ST_ABSENT;
              end else begin
                pos_we = 1'b1; pos_wd = '0;
                gone_nxt = key_q;
                i_nxt = pos_q;
                cnt_nxt = cnt_r - CW'(1);
                if (pos_q <= cnt_r - CW'(1)) state_nxt = S_ER_A;
              end
            end
            KIND_READ: res_key_nxt = 32'(key_q);
            KIND_EXTRACT, KIND_PEEK: begin
              if (cnt_r == '0) begin
                res_st_nxt = ST_EMPTY;
              end else begin
                lit_nxt = slot_q;
                key_ra = slot_q;
                state_nxt = S_TOPKEY;
              end
            end
            KIND_REINIT: begin
              res_key_nxt = cfg_dkey_r;
              sw_key_nxt = KW'($signed(cfg_dkey_r));
              sw_full_nxt = cfg_full_r;
              sw_n_nxt = lim;
              sw_rep_nxt = 1'b1;
              sw_cnt_nxt = '0;
              cnt_nxt = cfg_full_r ? lim : '0;
              state_nxt = S_SWEEP;
            end
            default: ;
          endcase
        end
      end
      S_TOPKEY: begin
        res_it_nxt = 10'(lit_r);
        res_key_nxt = 32'(key_q);
        state_nxt = S_DONE;
        if (kind_r == KIND_EXTRACT) begin
          pos_we = 1'b1; pos_wa = lit_r; pos_wd = '0;
          gone_nxt = key_q;
          i_nxt = CW'(1);
          cnt_nxt = cnt_r - CW'(1);
          if (cnt_r != CW'(1)) state_nxt = S_ER_A;
        end
      end
      S_ER_A: begin
        slot_ra = cnt_r + CW'(1);
        state_nxt = S_ER_B;
      end
      S_ER_B: begin
        mov_nxt = slot_q;
        key_ra = slot_q;
        state_nxt = S_ER_C;
      end
      S_ER_C: begin
        mkey_nxt = key_q;
        if (gone_r < key_q) state_nxt = S_SD_CHK;
        else if (key_q < gone_r) state_nxt = S_SU_CHK;
        else state_nxt = S_PLACE;
      end
      S_SU_CHK: begin
        slot_ra = i_r >> 1;
        state_nxt = (i_r == CW'(1)) ? S_PLACE : S_SU_A;
      end
      S_SU_A: begin
        lit_nxt = slot_q;
        key_ra = slot_q;
        state_nxt = S_SU_B;
      end
      S_SU_B: begin
        if (mkey_r >= key_q) begin
          state_nxt = S_PLACE;
        end else begin
          slot_we = 1'b1; slot_wa = i_r; slot_wd = lit_r;
          pos_we = 1'b1; pos_wa = lit_r; pos_wd = i_r;
          i_nxt = i_r >> 1;
          state_nxt = S_SU_CHK;
        end
      end
      S_SD_CHK: begin
        j_nxt = j2;
        slot_ra = CW'(j2);
        state_nxt = (j2 > {1'b0, cnt_r}) ? S_PLACE : S_SD_A;
      end
      S_SD_A: begin
        lit_nxt = slot_q;
        key_ra = slot_q;
        slot_ra = (j_r < {1'b0, cnt_r}) ? CW'(j_r + 1'b1) : CW'(j_r);
        state_nxt = S_SD_B;
      end
      S_SD_B, S_SD_C: begin
        if (state_r == S_SD_B) begin
          lkey_nxt = key_q;
          rit_nxt = slot_q;
          key_ra = slot_q;
          c_key = key_q;
        end else if (key_q < lkey_r) begin
          c_it = rit_r; c_key = key_q; c_j = j_r + 1'b1;
        end
        if ((state_r == S_SD_B) && (j_r < {1'b0, cnt_r})) begin
          state_nxt = S_SD_C;
        end else if (c_key >= mkey_r) begin
          state_nxt = S_PLACE;
        end else begin
          slot_we = 1'b1; slot_wa = i_r; slot_wd = c_it;
          pos_we = 1'b1; pos_wa = c_it; pos_wd = i_r;
          i_nxt = CW'(c_j);
          state_nxt = S_SD_CHK;
        end
      end
      S_PLACE: begin
        slot_we = 1'b1; slot_wa = i_r; slot_wd = mov_r;
        pos_we = 1'b1; pos_wa = mov_r; pos_wd = i_r;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          o_st_nxt = res_st_r;
          o_it_nxt = res_it_r;
          o_key_nxt = res_key_r;
          o_cnt_nxt = 11'(cnt_r);
          o_emp_nxt = (cnt_r == '0);
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      sw_cnt_r    <= '0;
      sw_rep_r    <= 1'b0;
      sw_full_r   <= 1'b0;
      sw_key_r    <= '0;
      cfg_items_r <= 11'd1024;
      cfg_dkey_r  <= '0;
      cfg_full_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      sw_cnt_r    <= sw_cnt_nxt;
      sw_rep_r    <= sw_rep_nxt;
      sw_full_r   <= sw_full_nxt;
      sw_key_r    <= sw_key_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_ITEMS_IN_USE: cfg_items_r <= cfg_data[10:0];
          REG_DEFAULT_KEY:  cfg_dkey_r <= cfg_data;
          REG_START_FULL:   cfg_full_r <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    sw_n_r   <= sw_n_nxt;
    kind_r   <= kind_nxt;
    item_r   <= item_nxt;
    nk_r     <= nk_nxt;
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    mov_r    <= mov_nxt;
    lit_r    <= lit_nxt;
    rit_r    <= rit_nxt;
    mkey_r   <= mkey_nxt;
    lkey_r   <= lkey_nxt;
    gone_r   <= gone_nxt;
    res_st_r <= res_st_nxt;
    res_it_r <= res_it_nxt;
    res_key_r <= res_key_nxt;
    o_st_r   <= o_st_nxt;
    o_it_r   <= o_it_nxt;
    o_key_r  <= o_key_nxt;
    o_cnt_r  <= o_cnt_nxt;
    o_emp_r  <= o_emp_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_status   = o_st_r;
  assign out_item_out = o_it_r;
  assign out_key_out  = o_key_r;
  assign out_count    = o_cnt_r;
  assign out_is_empty = o_emp_r;

endmodule

// File: bench/indexed_min_heap_tb.sv
module indexed_min_heap_tb;
  import imh_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // kind 7 has no name in the package; the block treats it as a no-op
  localparam logic [2:0] KIND_NOP = 3'd7;
  localparam int NUM_SLOTS = 1024;

  typedef struct packed {
    logic [2:0]         status;
    logic [9:0]         item;
    logic signed [31:0] key;
    logic [10:0]        count;
    logic               empty;
  } heap_result_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [2:0]         in_kind;
  logic [9:0]         in_item;
  logic signed [31:0] in_new_key;
  logic               out_valid;
  logic               out_stall;
  logic [2:0]         out_status;
  logic [9:0]         out_item_out;
  logic signed [31:0] out_key_out;
  logic [10:0]        out_count;
  logic               out_is_empty;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [31:0]        cfg_data;

  indexed_min_heap dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_kind(in_kind), .in_item(in_item), .in_new_key(in_new_key),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_item_out(out_item_out), .out_key_out(out_key_out),
    .out_count(out_count), .out_is_empty(out_is_empty),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Heap mirror: keys, slot array (1-based) and item -> slot map (0 = absent)
  // ---------------------------------------------------------------------------
  logic signed [31:0] key_mem [NUM_SLOTS];
  int                 slot_mem [NUM_SLOTS + 1];
  int                 slot_of [NUM_SLOTS];
  int                 heap_n;
  logic [10:0]        items_cfg;
  logic signed [31:0] dflt_key_cfg;
  bit                 full_cfg;

  heap_result_t result_q [$];   // results still owed by the block
  int  mismatches;
  int  sender_idle_pct;         // per item, chance of a gap before it
  int  stall_pct;               // per cycle, chance of out_stall
  int  hold_left;               // long receiver hold-off, in cycles

  function automatic int item_limit();
    return (items_cfg > NUM_SLOTS) ? NUM_SLOTS : int'(items_cfg);
  endfunction

  function automatic void put(int p, int it);
    slot_mem[p] = it;
    slot_of[it] = p;
  endfunction

  function automatic void sift_down(int k);
    int moving, i, j;
    moving = slot_mem[k];
    i = k;
    j = k * 2;
    while (j <= heap_n) begin
      // left child wins ties
      if (j < heap_n && key_mem[slot_mem[j + 1]] < key_mem[slot_mem[j]]) j++;
      if (key_mem[slot_mem[j]] >= key_mem[moving]) break;
      put(i, slot_mem[j]);
      i = j;
      j = i * 2;
    end
    if (i != k) put(i, moving);
  endfunction

  function automatic void sift_up(int k);
    int moving, i, p;
    moving = slot_mem[k];
    i = k;
    while (i > 1) begin
      p = i / 2;
      if (key_mem[moving] >= key_mem[slot_mem[p]]) break;
      put(i, slot_mem[p]);
      i = p;
    end
    if (i != k) put(i, moving);
  endfunction

  // caller clears the item's slot_of entry first
  function automatic void erase_slot(int p);
    int gone;
    if (heap_n == 0) return;
    heap_n--;
    if (p > heap_n) return;
    gone = slot_mem[p];
    put(p, slot_mem[heap_n + 1]);
    if (key_mem[gone] < key_mem[slot_mem[p]]) sift_down(p);
    else if (key_mem[slot_mem[p]] < key_mem[gone]) sift_up(p);
  endfunction

  function automatic void clear_mirror();
    for (int i = 0; i < NUM_SLOTS; i++) begin
      key_mem[i] = '0;
      slot_of[i] = 0;
    end
    for (int i = 0; i <= NUM_SLOTS; i++) slot_mem[i] = 0;
    heap_n       = 0;
    items_cfg    = 11'd1024;
    dflt_key_cfg = '0;
    full_cfg     = 0;
  endfunction

  function automatic heap_result_t heap_apply(logic [2:0] kind, logic [9:0] it,
                                              logic signed [31:0] nk);
    heap_result_t r;
    int           p;
    logic signed [31:0] cur;
    bit           addressed;
    r = '0;
    addressed = (kind == KIND_UPDATE || kind == KIND_DECREASE ||
                 kind == KIND_REMOVE || kind == KIND_READ);
    if (addressed) begin
      r.item = it;
      if (int'(it) >= item_limit()) begin
        r.status  = ST_BAD_ITEM;
        addressed = 0;
      end
    end
    if (addressed) begin
      p   = slot_of[it];
      cur = key_mem[it];
      case (kind)
        KIND_UPDATE, KIND_DECREASE: begin
          if (p == 0) begin
            key_mem[it] = nk;
            if (heap_n < NUM_SLOTS) begin
              heap_n++;
              put(heap_n, it);
              sift_up(heap_n);
            end
          end else if (nk < cur) begin
            key_mem[it] = nk;
            sift_up(p);
          end else if (kind == KIND_DECREASE) begin
            r.status = ST_NO_DEC;
          end else if (nk > cur) begin
            key_mem[it] = nk;
            sift_down(p);
          end
          r.key = key_mem[it];
        end
        KIND_REMOVE: begin
          r.key = cur;
          if (p == 0) r.status = ST_ABSENT;
          else begin
            slot_of[it] = 0;
            erase_slot(p);
          end
        end
        default: r.key = cur;
      endcase
    end else if (kind == KIND_EXTRACT || kind == KIND_PEEK) begin
      if (heap_n == 0) r.status = ST_EMPTY;
      else begin
        r.item = slot_mem[1];
        r.key  = key_mem[slot_mem[1]];
        if (kind == KIND_EXTRACT) begin
          slot_of[slot_mem[1]] = 0;
          erase_slot(1);
        end
      end
    end else if (kind == KIND_REINIT) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        key_mem[i] = dflt_key_cfg;
        slot_of[i] = 0;
      end
      heap_n = 0;
      if (full_cfg) begin
        for (int i = 0; i < item_limit(); i++) put(i + 1, i);
        heap_n = item_limit();
      end
      r.key = dflt_key_cfg;
    end
    r.count = heap_n[10:0];
    r.empty = (heap_n == 0);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, timeout, receiver
  // ---------------------------------------------------------------------------
  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("indexed_min_heap test failed");
    $finish;
  end

  // out_stall changes on the falling edge; a pending hold-off wins
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall = 1;
      hold_left--;
    end else begin
      out_stall = ($urandom_range(0, 99) < stall_pct);
    end
  end

  // result checker: every accepted result against the oldest expectation
  always @(posedge clk) begin
    heap_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (result_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d item %0d key %0d count %0d",
                   out_status, out_item_out, out_key_out, out_count);
      end else begin
        want = result_q.pop_front();
        if (out_status !== want.status || out_item_out !== want.item ||
            out_key_out !== want.key || out_count !== want.count ||
            out_is_empty !== want.empty) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp st %0d item %0d key %0d cnt %0d emp %0d,",
                      " got st %0d item %0d key %0d cnt %0d emp %0d"},
                     want.status, want.item, want.key, want.count, want.empty,
                     out_status, out_item_out, out_key_out, out_count, out_is_empty);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // one request item; returns at the accepting rising edge with valid still up
  task automatic send_req(logic [2:0] kind, logic [9:0] it, logic signed [31:0] nk);
    int gap;
    @(negedge clk);
    gap = ($urandom_range(0, 99) < sender_idle_pct) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_valid = 0;
      repeat (gap) @(negedge clk);
    end
    in_kind    = kind;
    in_item    = it;
    in_new_key = nk;
    in_valid   = 1;
    do @(posedge clk); while (in_stall);
    result_q.push_back(heap_apply(kind, it, nk));
  endtask

  // drop valid and wait for every owed result
  task automatic drain();
    @(negedge clk);
    in_valid = 0;
    while (result_q.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_index = idx;
    cfg_data  = val;
    cfg_valid = 1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ITEMS_IN_USE: items_cfg    = val[10:0];
      REG_DEFAULT_KEY:  dflt_key_cfg = val;
      REG_START_FULL:   full_cfg     = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0: begin sender_idle_pct = 0;  stall_pct = 0;  end
      1: begin sender_idle_pct = 55; stall_pct = 0;  end
      2: begin sender_idle_pct = 0;  stall_pct = 55; end
      default: begin sender_idle_pct = 33; stall_pct = 33; end
    endcase
  endtask

  function automatic logic signed [31:0] pick_key();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 15) - 8;         // dense: lots of ties
      1: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [9:0] pick_item();
    int lim;
    lim = item_limit();
    if (lim == 0 || $urandom_range(0, 19) == 0) return 10'($urandom);
    // mostly a small window so items get revisited; sometimes just past the limit
    return 10'($urandom_range(0, (lim < 48 ? lim : 48) + ($urandom_range(0, 9) == 0)));
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // hand-picked cases: empty heap, extreme keys, every kind, each error status
  task automatic test_directed();
    set_idling(0);
    send_req(KIND_PEEK,     0, 0);
    send_req(KIND_EXTRACT,  0, 0);
    send_req(KIND_REMOVE,   3, 0);                 // absent
    send_req(KIND_UPDATE,   1023, 32'sh7fff_ffff);
    send_req(KIND_UPDATE,   0, 32'sh8000_0000);
    send_req(KIND_UPDATE,   5, -1);
    send_req(KIND_UPDATE,   6, 0);
    send_req(KIND_UPDATE,   6, 0);                 // equal key: no move
    send_req(KIND_UPDATE,   0, 32'sh7fff_ffff);    // raise: sift down
    send_req(KIND_DECREASE, 5, 3);                 // not lower
    send_req(KIND_DECREASE, 5, 32'sh8000_0000);    // lower: sift up
    send_req(KIND_DECREASE, 9, 7);                 // absent: inserts
    send_req(KIND_PEEK,     0, 0);
    send_req(KIND_READ,     1023, 0);
    send_req(KIND_READ,     700, 0);               // never in heap
    send_req(KIND_REMOVE,   6, 0);
    send_req(KIND_EXTRACT,  0, 0);
    send_req(KIND_NOP,      1023, -1);
    send_req(KIND_REINIT,   0, 0);
    drain();
    cfg_write(REG_ITEMS_IN_USE, 5);
    send_req(KIND_UPDATE,   5, 1);                 // bad item
    send_req(KIND_READ,     1023, 0);              // bad item
    send_req(KIND_UPDATE,   4, 1);
    drain();
  endtask

  task automatic run_random(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 36)      send_req(KIND_UPDATE,   pick_item(), pick_key());
      else if (r < 50) send_req(KIND_DECREASE, pick_item(), pick_key());
      else if (r < 70) send_req(KIND_EXTRACT,  10'($urandom), $urandom);
      else if (r < 82) send_req(KIND_REMOVE,   pick_item(), $urandom);
      else if (r < 89) send_req(KIND_PEEK,     10'($urandom), $urandom);
      else if (r < 96) send_req(KIND_READ,     pick_item(), $urandom);
      else if (r < 98) send_req(KIND_NOP,      10'($urandom), $urandom);
      else             send_req(KIND_REINIT,   10'($urandom), $urandom);
    end
  endtask

  // several register settings, each under another idling mix
  task automatic test_config_phases();
    logic [31:0] use_tab  [7] = '{1024, 1, 2047, 40, 0, 300, 1024};
    logic [31:0] dkey_tab [7] = '{0, 32'h8000_0000, 32'h7fff_ffff, 5, 32'hffff_fffd, 0, 1};
    bit          full_tab [7] = '{0, 1, 1, 0, 1, 1, 0};
    int          len_tab  [7] = '{200, 100, 220, 200, 40, 200, 160};
    for (int p = 0; p < 7; p++) begin
      drain();
      cfg_write(REG_ITEMS_IN_USE, use_tab[p]);
      cfg_write(REG_DEFAULT_KEY,  (p == 5) ? $urandom : dkey_tab[p]);
      cfg_write(REG_START_FULL,   full_tab[p]);
      set_idling(p % 4);
      send_req(KIND_REINIT, 0, 0);
      run_random(len_tab[p]);
    end
    drain();
  endtask

  // receiver holds off while requests keep coming, so the input backs up
  task automatic test_backpressure();
    set_idling(0);
    send_req(KIND_UPDATE, 1, 10);
    hold_left = 400;
    run_random(30);
    drain();
    // sender pause: nothing owed, then more traffic
    repeat (20) @(negedge clk);
    set_idling(3);
    run_random(40);
    drain();
  endtask

  initial begin
    rst_n      = 0;
    in_valid   = 0;
    in_kind    = KIND_NOP;
    in_item    = '0;
    in_new_key = '0;
    cfg_valid  = 0;
    cfg_index  = REG_ITEMS_IN_USE;
    cfg_data   = '0;
    mismatches = 0;
    hold_left  = 0;
    set_idling(0);
    clear_mirror();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    test_directed();
    test_config_phases();
    test_backpressure();

    drain();
    repeat (60) @(posedge clk);
    if (mismatches == 0) begin
      $display("indexed_min_heap test passed");
    end else begin
      $display("indexed_min_heap test failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/imh_pkg.sv
rtl/indexed_min_heap.sv
bench/indexed_min_heap_tb.sv
